[rtl/mbg_pkg.sv]
// mbg_pkg: shared constants, codes, FSM state type and small pick helpers
// for the maze backtracker generator. No dependencies.
package mbg_pkg;

    localparam int MAX_COLUMNS_DEF = 64;
    localparam int MAX_ROWS_DEF    = 64;

    localparam int CFG_W     = 7;
    localparam int GRID_W    = 9;   // holds 1..256
    localparam int RND_W     = 8;
    localparam int POS_W     = 6;
    localparam int STEP_W    = 2;
    localparam int KIND_W    = 2;
    localparam int EVENT_W   = 3;
    localparam int DIR_W     = 2;
    localparam int WALL_W    = 4;
    localparam int CELL_W    = 5;   // walls in [3:0], visited in [4]
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 16;

    localparam logic [CFG_W-1:0]  GRID_RESET = 7'd16;
    localparam logic [WALL_W-1:0] WALLS_ALL  = 4'hF;

    localparam logic CFG_COLUMNS = 1'b0;
    localparam logic CFG_ROWS    = 1'b1;

    localparam logic [KIND_W-1:0] KIND_STEP    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_QUERY   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;

    localparam logic [DIR_W-1:0] DIR_TOP    = 2'd0;
    localparam logic [DIR_W-1:0] DIR_RIGHT  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_BOTTOM = 2'd2;
    localparam logic [DIR_W-1:0] DIR_LEFT   = 2'd3;

    typedef enum logic [EVENT_W-1:0] {
        EV_ADVANCED,
        EV_BACKTRACKED,
        EV_FINISHED,
        EV_IDLE,
        EV_QUERY,
        EV_RESTARTED
    } event_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_CUR,
        ST_RD_NB,
        ST_LAST_NB,
        ST_PICK,
        ST_WR_CUR,
        ST_WR_NB,
        ST_POP,
        ST_Q_RD,
        ST_Q_CHK,
        ST_OUT
    } state_t;

    // 0 reads as 1, anything above the maximum reads as the maximum
    function automatic logic [GRID_W-1:0] grid_clamp(logic [CFG_W-1:0] v, int unsigned maxv);
        logic [GRID_W-1:0] r;
        if (v == '0)
            r = GRID_W'(1);
        else if (32'(v) > maxv)
            r = GRID_W'(maxv);
        else
            r = GRID_W'(v);
        return r;
    endfunction

    // byte mod 3: base-4 digit sum taken twice, then two conditional subtracts
    function automatic logic [1:0] mod3(logic [RND_W-1:0] v);
        logic [3:0] s;
        logic [2:0] t;
        s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
        t = 3'(s[3:2]) + 3'(s[1:0]);
        if (t >= 3'd3)
            t = t - 3'd3;
        if (t >= 3'd3)
            t = t - 3'd3;
        return t[1:0];
    endfunction

    function automatic logic [1:0] pick_index(logic [RND_W-1:0] rnd, logic [2:0] cnt);
        logic [1:0] r;
        unique case (cnt)
            3'd2:    r = {1'b0, rnd[0]};
            3'd3:    r = mod3(rnd);
            3'd4:    r = rnd[1:0];
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] ones4(logic [3:0] m);
        return 3'(m[0]) + 3'(m[1]) + 3'(m[2]) + 3'(m[3]);
    endfunction

    // position of the n-th set bit of m, counting from bit 0
    function automatic logic [DIR_W-1:0] nth_set(logic [3:0] m, logic [1:0] n);
        logic [DIR_W-1:0] sel;
        logic [2:0]       seen;
        sel  = DIR_TOP;
        seen = 3'd0;
        for (int i = 0; i < 4; i++)
        begin
            if (m[i])
            begin
                if (seen == 3'(n))
                    sel = DIR_W'(i);
                seen = seen + 3'd1;
            end
        end
        return sel;
    endfunction

endpackage

[rtl/mbg_cell_store.sv]
// mbg_cell_store: single-port cell memory (walls + visited) with a clearing
// sweep after reset or on request. Depends on mbg_pkg.
module mbg_cell_store #(
    parameter int AW = 12
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       clear_start,
    input  logic                       we,
    input  logic [AW-1:0]              addr,
    input  logic [mbg_pkg::CELL_W-1:0] wdata,
    output logic [mbg_pkg::CELL_W-1:0] rdata,
    output logic                       clear_busy
);

    localparam int DEPTH = 1 << AW;

    logic [mbg_pkg::CELL_W-1:0] mem [DEPTH];
    logic [mbg_pkg::CELL_W-1:0] rdata_reg;
    logic                       busy_reg;
    logic [AW-1:0]              sweep_reg;
    logic [mbg_pkg::CELL_W-1:0] sweep_data;

    // origin comes out visited, every other cell unvisited
    assign sweep_data = (sweep_reg == '0) ? {1'b1, mbg_pkg::WALLS_ALL}
                                          : {1'b0, mbg_pkg::WALLS_ALL};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b1;
            sweep_reg <= '0;
        end
        else if (clear_start)
        begin
            busy_reg  <= 1'b1;
            sweep_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (sweep_reg == {AW{1'b1}})
                busy_reg <= 1'b0;
            sweep_reg <= sweep_reg + AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
            mem[sweep_reg] <= sweep_data;
        else if (we)
            mem[addr] <= wdata;
        rdata_reg <= mem[addr];
    end

    assign rdata      = rdata_reg;
    assign clear_busy = busy_reg;

endmodule

[rtl/mbg_stack.sv]
// mbg_stack: backtrack stack of cell addresses in a synchronous memory,
// with its fill count. No dependencies.
module mbg_stack #(
    parameter int DEPTH = 4096,
    parameter int DW    = 12
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          clear,
    input  logic          push,
    input  logic [DW-1:0] push_data,
    input  logic          pop,
    output logic [DW-1:0] pop_data,
    output logic          empty
);

    localparam int SA_W = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] pop_data_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_dec;
    logic          full;

    assign full      = (count_reg == CW'(DEPTH));
    assign count_dec = count_reg - CW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (clear)
            count_reg <= '0;
        else if (push && !full)
            count_reg <= count_reg + CW'(1);
        else if (pop && (count_reg != '0))
            count_reg <= count_dec;
    end

    // push beyond the depth is dropped
    always_ff @(posedge clk)
    begin
        if (push && !full)
            mem[count_reg[SA_W-1:0]] <= push_data;
        pop_data_reg <= mem[count_dec[SA_W-1:0]];
    end

    assign pop_data = pop_data_reg;
    assign empty    = (count_reg == '0);

endmodule

[rtl/maze_backtracker_generator.sv]
// maze_backtracker_generator: randomized depth-first maze carver.
// A restart answers only once the sweep of the cell memory is done.
// Throughput: one item at a time; the single cell-memory port (one access
//   per cycle: current cell, four neighbors, two write-backs) sets the rate.
// Reset: cell memory sweep over all 2^(XW+YW) entries, no item accepted meanwhile.
module maze_backtracker_generator #(
    parameter int MAX_COLUMNS = mbg_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = mbg_pkg::MAX_ROWS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write port
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [mbg_pkg::CFG_W-1:0]     cfg_data,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [7:0] random_value, [13:8] pos_x, [19:14] pos_y,
    // [21:20] step_x, [23:22] step_y
    input  logic [mbg_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] kind
    input  logic [mbg_pkg::KIND_W-1:0]    s_tuser,
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] move_open, [1] still_generating, [7:2] cursor_x,
    // [13:8] cursor_y, [15:14] carved_direction
    output logic [mbg_pkg::M_TDATA_W-1:0] m_tdata,
    // [2:0] event_res
    output logic [mbg_pkg::EVENT_W-1:0]   m_tuser
);

    localparam int XW    = $clog2(MAX_COLUMNS);
    localparam int YW    = $clog2(MAX_ROWS);
    localparam int AW    = XW + YW;
    localparam int GW    = mbg_pkg::GRID_W;
    localparam int EW    = GW + 1;       // signed neighbor coordinates
    localparam int PW    = mbg_pkg::POS_W;
    localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;

    mbg_pkg::state_t state_reg, state_next;

    // configuration, stored already clamped
    logic [GW-1:0] cols_reg, rows_reg;

    // generator state
    logic [XW-1:0] cur_x_reg;
    logic [YW-1:0] cur_y_reg;
    logic          gen_reg;

    // latched input beat
    logic [mbg_pkg::RND_W-1:0]  rnd_reg;
    logic [PW-1:0]              pos_x_reg, pos_y_reg;
    logic [1:0]                 step_x_reg, step_y_reg;

    // step work registers
    logic [mbg_pkg::DIR_W-1:0]  dir_reg;
    logic [mbg_pkg::CELL_W-1:0] cur_cell_reg;
    logic [mbg_pkg::WALL_W-1:0] nb_walls_reg [4];
    logic [3:0]                 mask_reg;
    logic [mbg_pkg::DIR_W-1:0]  pick_reg;
    logic                       q_ok_reg;
    logic [mbg_pkg::DIR_W-1:0]  q_dir_reg;
    logic                       restart_reg;

    // result staging and output register
    mbg_pkg::event_t            event_reg;
    logic                       open_reg;
    logic [mbg_pkg::DIR_W-1:0]  carved_reg;
    logic                       m_tvalid_reg;
    logic [mbg_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic [mbg_pkg::EVENT_W-1:0]   m_tuser_reg;

    // memory and stack hookup
    logic                       cell_we;
    logic [AW-1:0]              cell_addr;
    logic [mbg_pkg::CELL_W-1:0] cell_wdata;
    logic [mbg_pkg::CELL_W-1:0] cell_rdata;
    logic                       clear_start;
    logic                       clear_busy;
    logic                       stk_push, stk_pop, stk_empty;
    logic [AW-1:0]              stk_pop_data;

    logic          in_beat;
    logic          out_free;
    logic [XW-1:0] nb_x  [4];
    logic [YW-1:0] nb_y  [4];
    logic          nb_in [4];
    logic [2:0]    cand_cnt;

    // query geometry
    logic [EW-1:0]             q_src_x, q_src_y, q_dst_x, q_dst_y;
    logic                      q_src_in, q_dst_in, q_dir_ok;
    logic [mbg_pkg::DIR_W-1:0] q_dir;

    assign in_beat  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign cand_cnt = mbg_pkg::ones4(mask_reg);

    // ---------------------------------------------------------------
    // Neighbor coordinates of the current cell, with an in-grid check
    // on both axes (the cursor may sit outside a shrunk grid).
    // ---------------------------------------------------------------
    always_comb
    begin
        logic [EW-1:0] ox, oy, nx, ny;
        for (int d = 0; d < 4; d++)
        begin
            unique case (mbg_pkg::DIR_W'(d))
                mbg_pkg::DIR_TOP:    begin ox = '0;        oy = {EW{1'b1}}; end
                mbg_pkg::DIR_RIGHT:  begin ox = EW'(1);    oy = '0;         end
                mbg_pkg::DIR_BOTTOM: begin ox = '0;        oy = EW'(1);     end
                mbg_pkg::DIR_LEFT:   begin ox = {EW{1'b1}}; oy = '0;        end
            endcase
            nx       = EW'(cur_x_reg) + ox;
            ny       = EW'(cur_y_reg) + oy;
            nb_x[d]  = nx[XW-1:0];
            nb_y[d]  = ny[YW-1:0];
            nb_in[d] = !nx[EW-1] && !ny[EW-1] &&
                       (nx[GW-1:0] < cols_reg) && (ny[GW-1:0] < rows_reg);
        end
    end

    // ---------------------------------------------------------------
    // Query: both ends in grid and a unit move along one axis.
    // ---------------------------------------------------------------
    assign q_src_x  = EW'(pos_x_reg);
    assign q_src_y  = EW'(pos_y_reg);
    assign q_dst_x  = q_src_x + {{(EW-2){step_x_reg[1]}}, step_x_reg};
    assign q_dst_y  = q_src_y + {{(EW-2){step_y_reg[1]}}, step_y_reg};
    assign q_src_in = (q_src_x[GW-1:0] < cols_reg) && (q_src_y[GW-1:0] < rows_reg);
    assign q_dst_in = !q_dst_x[EW-1] && !q_dst_y[EW-1] &&
                      (q_dst_x[GW-1:0] < cols_reg) && (q_dst_y[GW-1:0] < rows_reg);

    always_comb
    begin
        q_dir_ok = 1'b1;
        q_dir    = mbg_pkg::DIR_TOP;
        priority if (step_x_reg == 2'b00 && step_y_reg == 2'b11)
            q_dir = mbg_pkg::DIR_TOP;
        else if (step_x_reg == 2'b01 && step_y_reg == 2'b00)
            q_dir = mbg_pkg::DIR_RIGHT;
        else if (step_x_reg == 2'b00 && step_y_reg == 2'b01)
            q_dir = mbg_pkg::DIR_BOTTOM;
        else if (step_x_reg == 2'b11 && step_y_reg == 2'b00)
            q_dir = mbg_pkg::DIR_LEFT;
        else
            q_dir_ok = 1'b0;
    end

    // ---------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mbg_pkg::ST_CLEAR:
                if (!clear_busy)
                    state_next = restart_reg ? mbg_pkg::ST_OUT : mbg_pkg::ST_IDLE;
            mbg_pkg::ST_IDLE:
                if (in_beat)
                begin
                    priority if (s_tuser == mbg_pkg::KIND_STEP)
                        state_next = gen_reg ? mbg_pkg::ST_RD_CUR : mbg_pkg::ST_OUT;
                    else if (s_tuser == mbg_pkg::KIND_QUERY)
                        state_next = mbg_pkg::ST_Q_RD;
                    else if (s_tuser == mbg_pkg::KIND_RESTART)
                        state_next = mbg_pkg::ST_CLEAR;
                    else
                        state_next = mbg_pkg::ST_OUT;
                end
            mbg_pkg::ST_RD_CUR:
                state_next = mbg_pkg::ST_RD_NB;
            mbg_pkg::ST_RD_NB:
                if (dir_reg == mbg_pkg::DIR_LEFT)
                    state_next = mbg_pkg::ST_LAST_NB;
            mbg_pkg::ST_LAST_NB:
                state_next = mbg_pkg::ST_PICK;
            mbg_pkg::ST_PICK:
                priority if (cand_cnt != 3'd0)
                    state_next = mbg_pkg::ST_WR_CUR;
                else if (!stk_empty)
                    state_next = mbg_pkg::ST_POP;
                else
                    state_next = mbg_pkg::ST_OUT;
            mbg_pkg::ST_WR_CUR:
                state_next = mbg_pkg::ST_WR_NB;
            mbg_pkg::ST_WR_NB:
                state_next = mbg_pkg::ST_OUT;
            mbg_pkg::ST_POP:
                state_next = mbg_pkg::ST_OUT;
            mbg_pkg::ST_Q_RD:
                state_next = mbg_pkg::ST_Q_CHK;
            mbg_pkg::ST_Q_CHK:
                state_next = mbg_pkg::ST_OUT;
            mbg_pkg::ST_OUT:
                if (out_free)
                    state_next = mbg_pkg::ST_IDLE;
            default:
                state_next = mbg_pkg::ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Memory port, stack and handshake controls
    // ---------------------------------------------------------------
    always_comb
    begin
        s_tready    = 1'b0;
        cell_we     = 1'b0;
        cell_addr   = {cur_y_reg, cur_x_reg};
        cell_wdata  = cur_cell_reg;
        clear_start = 1'b0;
        stk_push    = 1'b0;
        stk_pop     = 1'b0;
        unique case (state_reg)
            mbg_pkg::ST_IDLE:
            begin
                s_tready    = 1'b1;
                clear_start = in_beat && (s_tuser == mbg_pkg::KIND_RESTART);
            end
            mbg_pkg::ST_RD_NB:
                cell_addr = {nb_y[dir_reg], nb_x[dir_reg]};
            mbg_pkg::ST_PICK:
                stk_pop = (cand_cnt == 3'd0) && !stk_empty;
            mbg_pkg::ST_WR_CUR:
            begin
                // carve the wall on the current cell and push it
                cell_we    = 1'b1;
                cell_wdata = cur_cell_reg & ~(mbg_pkg::CELL_W'(1) << pick_reg);
                stk_push   = 1'b1;
            end
            mbg_pkg::ST_WR_NB:
            begin
                // opposite wall on the neighbor, mark it visited
                cell_we    = 1'b1;
                cell_addr  = {nb_y[pick_reg], nb_x[pick_reg]};
                cell_wdata = {1'b1, nb_walls_reg[pick_reg] &
                              ~(mbg_pkg::WALL_W'(1) << (pick_reg + mbg_pkg::DIR_W'(2)))};
            end
            mbg_pkg::ST_Q_RD:
                cell_addr = {q_src_y[YW-1:0], q_src_x[XW-1:0]};
            default:
            begin
            end
        endcase
    end

    // ---------------------------------------------------------------
    // State and datapath registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= mbg_pkg::ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= mbg_pkg::grid_clamp(mbg_pkg::GRID_RESET, MAX_COLUMNS);
            rows_reg <= mbg_pkg::grid_clamp(mbg_pkg::GRID_RESET, MAX_ROWS);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mbg_pkg::CFG_COLUMNS: cols_reg <= mbg_pkg::grid_clamp(cfg_data, MAX_COLUMNS);
                mbg_pkg::CFG_ROWS:    rows_reg <= mbg_pkg::grid_clamp(cfg_data, MAX_ROWS);
            endcase
        end
    end

    // control-side generator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg   <= '0;
            cur_y_reg   <= '0;
            gen_reg     <= 1'b1;
            restart_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                mbg_pkg::ST_IDLE:
                    if (in_beat && (s_tuser == mbg_pkg::KIND_RESTART))
                    begin
                        cur_x_reg   <= '0;
                        cur_y_reg   <= '0;
                        gen_reg     <= 1'b1;
                        restart_reg <= 1'b1;
                    end
                mbg_pkg::ST_PICK:
                    if ((cand_cnt == 3'd0) && stk_empty)
                        gen_reg <= 1'b0;
                mbg_pkg::ST_WR_NB:
                begin
                    cur_x_reg <= nb_x[pick_reg];
                    cur_y_reg <= nb_y[pick_reg];
                end
                mbg_pkg::ST_POP:
                    {cur_y_reg, cur_x_reg} <= stk_pop_data;
                mbg_pkg::ST_OUT:
                    restart_reg <= 1'b0;
                default:
                begin
                end
            endcase
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            mbg_pkg::ST_IDLE:
                if (in_beat)
                begin
                    rnd_reg    <= s_tdata[7:0];
                    pos_x_reg  <= s_tdata[13:8];
                    pos_y_reg  <= s_tdata[19:14];
                    step_x_reg <= s_tdata[21:20];
                    step_y_reg <= s_tdata[23:22];
                    open_reg   <= 1'b0;
                    carved_reg <= mbg_pkg::DIR_TOP;
                    mask_reg   <= '0;
                    event_reg  <= (s_tuser == mbg_pkg::KIND_RESTART) ?
                                  mbg_pkg::EV_RESTARTED : mbg_pkg::EV_IDLE;
                end
            mbg_pkg::ST_RD_CUR:
                dir_reg <= mbg_pkg::DIR_TOP;
            mbg_pkg::ST_RD_NB:
            begin
                // data returning now belongs to the previous address
                if (dir_reg == mbg_pkg::DIR_TOP)
                    cur_cell_reg <= cell_rdata;
                else
                begin
                    nb_walls_reg[dir_reg - mbg_pkg::DIR_W'(1)] <= cell_rdata[3:0];
                    mask_reg[dir_reg - mbg_pkg::DIR_W'(1)] <=
                        nb_in[dir_reg - mbg_pkg::DIR_W'(1)] && !cell_rdata[4];
                end
                dir_reg <= dir_reg + mbg_pkg::DIR_W'(1);
            end
            mbg_pkg::ST_LAST_NB:
            begin
                nb_walls_reg[mbg_pkg::DIR_LEFT] <= cell_rdata[3:0];
                mask_reg[mbg_pkg::DIR_LEFT] <= nb_in[mbg_pkg::DIR_LEFT] && !cell_rdata[4];
            end
            mbg_pkg::ST_PICK:
            begin
                pick_reg  <= mbg_pkg::nth_set(mask_reg,
                                              mbg_pkg::pick_index(rnd_reg, cand_cnt));
                event_reg <= (cand_cnt != 3'd0) ? mbg_pkg::EV_ADVANCED :
                             (!stk_empty ? mbg_pkg::EV_BACKTRACKED : mbg_pkg::EV_FINISHED);
            end
            mbg_pkg::ST_WR_NB:
                carved_reg <= pick_reg;
            mbg_pkg::ST_Q_RD:
            begin
                q_ok_reg  <= q_src_in && q_dst_in && q_dir_ok;
                q_dir_reg <= q_dir;
            end
            mbg_pkg::ST_Q_CHK:
            begin
                open_reg  <= q_ok_reg && !cell_rdata[q_dir_reg];
                event_reg <= mbg_pkg::EV_QUERY;
            end
            default:
            begin
            end
        endcase
    end

    // output register: loaded from the staged result when free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if ((state_reg == mbg_pkg::ST_OUT) && out_free)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        logic [7:0] cx8;
        logic [7:0] cy8;
        cx8 = 8'(cur_x_reg);
        cy8 = 8'(cur_y_reg);
        if ((state_reg == mbg_pkg::ST_OUT) && out_free)
        begin
            m_tuser_reg <= event_reg;
            m_tdata_reg <= {carved_reg, cy8[5:0], cx8[5:0], gen_reg, open_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ---------------------------------------------------------------
    // Storage
    // ---------------------------------------------------------------
    mbg_cell_store #(
        .AW (AW)
    ) u_cell_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .clear_start (clear_start),
        .we          (cell_we),
        .addr        (cell_addr),
        .wdata       (cell_wdata),
        .rdata       (cell_rdata),
        .clear_busy  (clear_busy)
    );

    mbg_stack #(
        .DEPTH (DEPTH),
        .DW    (AW)
    ) u_stack (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (clear_start),
        .push      (stk_push),
        .push_data ({cur_y_reg, cur_x_reg}),
        .pop       (stk_pop),
        .pop_data  (stk_pop_data),
        .empty     (stk_empty)
    );

endmodule

[tb/tb.sv]
// tb: self-checking bench for the maze backtracker generator.
// Needs rtl/mbg_pkg.sv, rtl/mbg_cell_store.sv, rtl/mbg_stack.sv and
// rtl/maze_backtracker_generator.sv; a scoreboard class tracks walls and stack.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID_MAX_X   = mbg_pkg::MAX_COLUMNS_DEF;
    localparam int GRID_MAX_Y   = mbg_pkg::MAX_ROWS_DEF;
    localparam int CELL_COUNT   = GRID_MAX_X * GRID_MAX_Y;
    localparam int RANDOM_BEATS = 1080;
    localparam int PHASES       = 9;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int VISITED      = 4;    // visited flag position in a cell entry

    // kind code the block leaves unused
    localparam logic [mbg_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

    // two-bit signed move offsets
    localparam logic [mbg_pkg::STEP_W-1:0] STEP_ZERO = 2'b00;
    localparam logic [mbg_pkg::STEP_W-1:0] STEP_POS  = 2'b01;
    localparam logic [mbg_pkg::STEP_W-1:0] STEP_NEG2 = 2'b10;
    localparam logic [mbg_pkg::STEP_W-1:0] STEP_NEG  = 2'b11;

    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE,
        READY_DUTY
    } ready_mode_t;

    typedef struct {
        logic [mbg_pkg::EVENT_W-1:0] ev;
        logic                        open;
        logic                        gen;
        logic [mbg_pkg::POS_W-1:0]   cx;
        logic [mbg_pkg::POS_W-1:0]   cy;
        logic [mbg_pkg::DIR_W-1:0]   dir;
    } maze_outcome_t;

    // Tracks the maze the block should be carving and the beats it owes.
    class maze_scoreboard;
        logic [mbg_pkg::CELL_W-1:0] cells [CELL_COUNT];
        int unsigned                trail [CELL_COUNT];  // cells to return to on a dead end
        int unsigned                trail_depth;
        int unsigned                cursor;
        bit                         carving;
        logic [mbg_pkg::CFG_W-1:0]  cols_reg;
        logic [mbg_pkg::CFG_W-1:0]  rows_reg;
        maze_outcome_t              maze_outcomes [$];
        int unsigned                errors;

        function new();
            cols_reg = mbg_pkg::GRID_RESET;
            rows_reg = mbg_pkg::GRID_RESET;
            errors   = 0;
            wipe_maze();
        endfunction

        // every wall up, only the origin visited, cursor home
        function void wipe_maze();
            foreach (cells[i])
                cells[i] = {1'b0, mbg_pkg::WALLS_ALL};
            cells[0]    = {1'b1, mbg_pkg::WALLS_ALL};
            trail_depth = 0;
            cursor      = 0;
            carving     = 1'b1;
        endfunction

        // register values 0 and above the maximum are clamped
        function int cols_in_use();
            if (cols_reg == 0)
                return 1;
            if (cols_reg > GRID_MAX_X)
                return GRID_MAX_X;
            return cols_reg;
        endfunction

        function int rows_in_use();
            if (rows_reg == 0)
                return 1;
            if (rows_reg > GRID_MAX_Y)
                return GRID_MAX_Y;
            return rows_reg;
        endfunction

        function bit on_grid(int x, int y);
            return x >= 0 && y >= 0 && x < cols_in_use() && y < rows_in_use();
        endfunction

        function void set_register(logic idx, logic [mbg_pkg::CFG_W-1:0] val);
            if (idx == mbg_pkg::CFG_COLUMNS)
                cols_reg = val;
            else
                rows_reg = val;
        endfunction

        // apply one accepted input beat and queue the result it must produce
        function void take_item(logic [mbg_pkg::KIND_W-1:0] kind,
                                logic [mbg_pkg::RND_W-1:0] rnd,
                                logic [mbg_pkg::POS_W-1:0] px,
                                logic [mbg_pkg::POS_W-1:0] py,
                                logic [mbg_pkg::STEP_W-1:0] sx,
                                logic [mbg_pkg::STEP_W-1:0] sy);
            maze_outcome_t             r;
            int                        x, y, dx, dy, cnt, pick;
            int                        nb_at [4];
            logic [mbg_pkg::DIR_W-1:0] nb_dir [4];
            logic [mbg_pkg::DIR_W-1:0] d;
            r.ev   = mbg_pkg::EV_IDLE;
            r.open = 1'b0;
            r.dir  = mbg_pkg::DIR_TOP;
            case (kind)
                mbg_pkg::KIND_STEP:
                begin
                    if (carving)
                    begin
                        x   = cursor % GRID_MAX_X;
                        y   = cursor / GRID_MAX_X;
                        cnt = 0;
                        // unvisited in-grid neighbors, top, right, bottom, left
                        for (int k = 0; k < 4; k++)
                        begin
                            dx = (k == mbg_pkg::DIR_RIGHT) ? 1 :
                                 (k == mbg_pkg::DIR_LEFT) ? -1 : 0;
                            dy = (k == mbg_pkg::DIR_BOTTOM) ? 1 :
                                 (k == mbg_pkg::DIR_TOP) ? -1 : 0;
                            if (on_grid(x + dx, y + dy))
                            begin
                                if (!cells[(y + dy) * GRID_MAX_X + x + dx][VISITED])
                                begin
                                    nb_dir[cnt] = mbg_pkg::DIR_W'(k);
                                    nb_at[cnt]  = (y + dy) * GRID_MAX_X + x + dx;
                                    cnt++;
                                end
                            end
                        end
                        if (cnt > 0)
                        begin
                            pick = rnd % cnt;
                            d    = nb_dir[pick];
                            cells[cursor][d]                          = 1'b0;
                            cells[nb_at[pick]][mbg_pkg::DIR_W'(d + 2)] = 1'b0;
                            cells[nb_at[pick]][VISITED]               = 1'b1;
                            if (trail_depth < CELL_COUNT)
                            begin
                                trail[trail_depth] = cursor;
                                trail_depth++;
                            end
                            cursor = nb_at[pick];
                            r.ev   = mbg_pkg::EV_ADVANCED;
                            r.dir  = d;
                        end
                        else if (trail_depth > 0)
                        begin
                            trail_depth--;
                            cursor = trail[trail_depth];
                            r.ev   = mbg_pkg::EV_BACKTRACKED;
                        end
                        else
                        begin
                            carving = 1'b0;
                            r.ev    = mbg_pkg::EV_FINISHED;
                        end
                    end
                end
                mbg_pkg::KIND_QUERY:
                begin
                    x    = px;
                    y    = py;
                    dx   = $signed(sx);
                    dy   = $signed(sy);
                    r.ev = mbg_pkg::EV_QUERY;
                    // only a unit move along one axis, both ends on the grid
                    if (on_grid(x, y) && on_grid(x + dx, y + dy) &&
                        ((dx == 0 && (dy == 1 || dy == -1)) ||
                         (dy == 0 && (dx == 1 || dx == -1))))
                    begin
                        d = (dy == -1) ? mbg_pkg::DIR_TOP : (dx == 1) ? mbg_pkg::DIR_RIGHT :
                            (dy == 1) ? mbg_pkg::DIR_BOTTOM : mbg_pkg::DIR_LEFT;
                        r.open = !cells[y * GRID_MAX_X + x][d];
                    end
                end
                mbg_pkg::KIND_RESTART:
                begin
                    wipe_maze();
                    r.ev = mbg_pkg::EV_RESTARTED;
                end
                default:
                    r.ev = mbg_pkg::EV_IDLE;
            endcase
            r.gen = carving;
            r.cx  = mbg_pkg::POS_W'(cursor % GRID_MAX_X);
            r.cy  = mbg_pkg::POS_W'(cursor / GRID_MAX_X);
            maze_outcomes.insert(maze_outcomes.size(), r);
        endfunction

        // compare one result beat with the oldest outstanding outcome
        function void match_result(logic [mbg_pkg::EVENT_W-1:0] ev,
                                   logic [mbg_pkg::M_TDATA_W-1:0] data);
            maze_outcome_t want;
            logic [7:0]    want_f [6];
            logic [7:0]    got_f [6];
            string         field_name [6];
            if (maze_outcomes.size() == 0)
            begin
                $display("%0t: unexpected result beat, expected none, actual event %0d data %h",
                         $time, ev, data);
                errors++;
                return;
            end
            want       = maze_outcomes.pop_front();
            field_name = '{"event_res", "move_open", "still_generating",
                           "cursor_x", "cursor_y", "carved_direction"};
            want_f     = '{8'(want.ev), 8'(want.open), 8'(want.gen),
                           8'(want.cx), 8'(want.cy), 8'(want.dir)};
            got_f      = '{8'(ev), 8'(data[0]), 8'(data[1]),
                           8'(data[7:2]), 8'(data[13:8]), 8'(data[15:14])};
            for (int i = 0; i < 6; i++)
            begin
                if (got_f[i] !== want_f[i])
                begin
                    $display("%0t: %s mismatch, expected %0d actual %0d",
                             $time, field_name[i], want_f[i], got_f[i]);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            cfg_we    = 1'b0;
    logic                            cfg_index = mbg_pkg::CFG_COLUMNS;
    logic [mbg_pkg::CFG_W-1:0]       cfg_data  = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [mbg_pkg::S_TDATA_W-1:0]   s_tdata   = '0;
    logic [mbg_pkg::KIND_W-1:0]      s_tuser   = mbg_pkg::KIND_STEP;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [mbg_pkg::M_TDATA_W-1:0]   m_tdata;
    logic [mbg_pkg::EVENT_W-1:0]     m_tuser;

    maze_scoreboard sb = new();

    int unsigned burst_left  = 0;   // beats left in the current sender burst
    bit          hold_req    = 1'b0;
    int unsigned hold_left   = 0;
    int unsigned mode_left   = 0;
    ready_mode_t ready_mode  = READY_ALWAYS;
    int unsigned cycle_count = 0;

    maze_backtracker_generator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Watchdog: most of a legal run goes to the memory sweep behind
    // every restart.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side. Values are read right after the edge, before the block's
    // nonblocking updates land, so a beat counts when both were high at it.
    // Ready follows a mode picked anew at random when the last one runs out; a hold request
    // parks ready low for a long stretch so the block backs up its input.
    always @(posedge clk)
    begin
        if (m_tvalid === 1'b1 && m_tready)
            sb.match_result(m_tuser, m_tdata);
        if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = 400;
        end
        if (mode_left == 0)
        begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            mode_left  = $urandom_range(8, 80);
        end
        mode_left--;
        if (hold_left != 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            case (ready_mode)
                READY_ALWAYS: m_tready <= 1'b1;
                READY_COIN:   m_tready <= 1'($urandom_range(0, 1));
                READY_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                default:      m_tready <= (mode_left % 8) < 5;
            endcase
        end
    end

    // Offer one beat and wait for it to be taken. Valid stays high from one
    // beat to the next inside a burst; a gap drops it before the next burst.
    task automatic offer_beat(input logic [mbg_pkg::KIND_W-1:0] kind,
                              input logic [mbg_pkg::RND_W-1:0] rnd,
                              input logic [mbg_pkg::POS_W-1:0] px,
                              input logic [mbg_pkg::POS_W-1:0] py,
                              input logic [mbg_pkg::STEP_W-1:0] sx,
                              input logic [mbg_pkg::STEP_W-1:0] sy);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {sy, sx, py, px, rnd};
        @(posedge clk);
        while (s_tready !== 1'b1)
            @(posedge clk);
        sb.take_item(kind, rnd, px, py, sx, sy);
    endtask

    // Drain, let the block settle, then load a new grid size. Every item
    // answers with one beat, so an empty scoreboard means the block is idle.
    task automatic regrid(input logic [mbg_pkg::CFG_W-1:0] cols,
                          input logic [mbg_pkg::CFG_W-1:0] rows);
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (sb.maze_outcomes.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= mbg_pkg::CFG_COLUMNS;
        cfg_data  <= cols;
        @(posedge clk);
        sb.set_register(mbg_pkg::CFG_COLUMNS, cols);
        cfg_index <= mbg_pkg::CFG_ROWS;
        cfg_data  <= rows;
        @(posedge clk);
        sb.set_register(mbg_pkg::CFG_ROWS, rows);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        logic [mbg_pkg::CFG_W-1:0]  phase_cols [PHASES];
        logic [mbg_pkg::CFG_W-1:0]  phase_rows [PHASES];
        logic [mbg_pkg::KIND_W-1:0] kind;
        logic [mbg_pkg::POS_W-1:0]  px, py;
        logic [mbg_pkg::STEP_W-1:0] sx, sy;
        int unsigned                roll;

        // small grids finish and go idle; 0, 127 and 65 hit the clamps
        phase_cols = '{7'd4, 7'd1, 7'd64, 7'd0, 7'd5, 7'd127, 7'd7, 7'd3, 7'd2};
        phase_rows = '{7'd4, 7'd7, 7'd64, 7'd3, 7'd2, 7'd1, 7'd6, 7'd65, 7'd2};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed, reset grid of 16 x 16 -------------------------------
        offer_beat(mbg_pkg::KIND_QUERY, 8'h00, 6'd0, 6'd0, STEP_POS, STEP_ZERO);  // walled
        offer_beat(mbg_pkg::KIND_STEP, 8'h00, 6'd0, 6'd0, STEP_ZERO, STEP_ZERO);  // carve right
        offer_beat(mbg_pkg::KIND_QUERY, 8'h00, 6'd0, 6'd0, STEP_POS, STEP_ZERO);  // now open
        offer_beat(mbg_pkg::KIND_QUERY, 8'hFF, 6'd1, 6'd0, STEP_NEG, STEP_ZERO);  // open back
        offer_beat(mbg_pkg::KIND_STEP, 8'hFF, 6'd63, 6'd63, STEP_NEG, STEP_NEG);
        offer_beat(mbg_pkg::KIND_STEP, 8'h80, 6'd0, 6'd0, STEP_ZERO, STEP_ZERO);
        offer_beat(mbg_pkg::KIND_QUERY, 8'h00, 6'd1, 6'd1, STEP_POS, STEP_POS);   // diagonal
        offer_beat(mbg_pkg::KIND_QUERY, 8'h00, 6'd1, 6'd1, STEP_ZERO, STEP_ZERO); // no move
        offer_beat(mbg_pkg::KIND_QUERY, 8'h00, 6'd5, 6'd5, STEP_NEG2, STEP_ZERO); // offset -2
        offer_beat(mbg_pkg::KIND_QUERY, 8'h00, 6'd5, 6'd5, STEP_ZERO, STEP_NEG2);
        offer_beat(mbg_pkg::KIND_QUERY, 8'h00, 6'd63, 6'd63, STEP_ZERO, STEP_NEG); // off grid
        offer_beat(mbg_pkg::KIND_QUERY, 8'h00, 6'd15, 6'd15, STEP_POS, STEP_ZERO); // lands off
        offer_beat(mbg_pkg::KIND_QUERY, 8'h00, 6'd0, 6'd0, STEP_ZERO, STEP_NEG);
        offer_beat(KIND_UNUSED, 8'hFF, 6'd63, 6'd63, STEP_NEG, STEP_NEG);
        offer_beat(mbg_pkg::KIND_RESTART, 8'h00, 6'd0, 6'd0, STEP_ZERO, STEP_ZERO);
        offer_beat(mbg_pkg::KIND_QUERY, 8'h00, 6'd0, 6'd0, STEP_POS, STEP_ZERO);  // walled again

        // single cell: finishes at once, then steps only idle
        regrid(7'd1, 7'd1);
        offer_beat(mbg_pkg::KIND_STEP, 8'h00, 6'd0, 6'd0, STEP_ZERO, STEP_ZERO);
        offer_beat(mbg_pkg::KIND_STEP, 8'hFF, 6'd0, 6'd0, STEP_ZERO, STEP_ZERO);
        offer_beat(mbg_pkg::KIND_QUERY, 8'h00, 6'd0, 6'd0, STEP_POS, STEP_ZERO);

        // zero registers read as one
        regrid(7'd0, 7'd0);
        offer_beat(mbg_pkg::KIND_RESTART, 8'h00, 6'd0, 6'd0, STEP_ZERO, STEP_ZERO);
        offer_beat(mbg_pkg::KIND_STEP, 8'h00, 6'd0, 6'd0, STEP_ZERO, STEP_ZERO);

        // all-ones registers clamp to the full 64 x 64 area
        regrid(7'd127, 7'd127);
        offer_beat(mbg_pkg::KIND_RESTART, 8'h00, 6'd0, 6'd0, STEP_ZERO, STEP_ZERO);
        offer_beat(mbg_pkg::KIND_QUERY, 8'h00, 6'd63, 6'd63, STEP_NEG, STEP_ZERO);
        offer_beat(mbg_pkg::KIND_QUERY, 8'h00, 6'd63, 6'd63, STEP_POS, STEP_ZERO);
        offer_beat(mbg_pkg::KIND_STEP, 8'h55, 6'd0, 6'd0, STEP_ZERO, STEP_ZERO);

        // --- random phases ------------------------------------------------
        // Mostly steps so carving runs deep; most queries land on or just past
        // the grid. A grid change mid-carve leaves the cursor where it is.
        for (int p = 0; p < PHASES; p++)
        begin
            regrid(phase_cols[p], phase_rows[p]);
            if (p == 1 || p == 5)
                hold_req = 1'b1;
            if ($urandom_range(0, 1) == 1)
                offer_beat(mbg_pkg::KIND_RESTART, 8'($urandom), 6'($urandom), 6'($urandom),
                           2'($urandom), 2'($urandom));
            for (int n = 0; n < RANDOM_BEATS / PHASES; n++)
            begin
                roll = $urandom_range(0, 99);
                kind = (roll < 62) ? mbg_pkg::KIND_STEP :
                       (roll < 90) ? mbg_pkg::KIND_QUERY :
                       (roll < 97) ? KIND_UNUSED : mbg_pkg::KIND_RESTART;
                px   = 6'($urandom);
                py   = 6'($urandom);
                sx   = 2'($urandom);
                sy   = 2'($urandom);
                if (kind == mbg_pkg::KIND_QUERY && $urandom_range(0, 7) != 0)
                begin
                    px = mbg_pkg::POS_W'($urandom_range(0, sb.cols_in_use()));
                    py = mbg_pkg::POS_W'($urandom_range(0, sb.rows_in_use()));
                    if ($urandom_range(0, 4) != 0)
                    begin
                        case ($urandom_range(0, 3))
                            0:       begin sx = STEP_ZERO; sy = STEP_NEG;  end
                            1:       begin sx = STEP_POS;  sy = STEP_ZERO; end
                            2:       begin sx = STEP_ZERO; sy = STEP_POS;  end
                            default: begin sx = STEP_NEG;  sy = STEP_ZERO; end
                        endcase
                    end
                end
                offer_beat(kind, 8'($urandom), px, py, sx, sy);
            end
        end

        // --- wind down ----------------------------------------------------
        s_tvalid <= 1'b0;
        while (sb.maze_outcomes.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (sb.errors == 0 && sb.maze_outcomes.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
